// ----- src/sstf_disk_request_scheduler_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the shortest-seek-first disk request scheduler
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SSTF_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sstf_pkg.sv -----
// ---------------------------------------------------------------------------
// Scheduler package
// Types, codes and default sizes shared by the scheduler modules.
// ---------------------------------------------------------------------------
package sstf_pkg;

  localparam int DEF_REQUESTERS = 8;
  localparam int DEF_TRACK_BITS = 10;

  localparam int ID_W   = 3;
  localparam int CFG_W  = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0] MAX_QUEUE_RST = 4'd1;
  localparam logic [CFG_W-1:0] NUM_REQ_RST   = 4'd8;

  localparam logic REG_MAX_QUEUE = 1'b0;
  localparam logic REG_NUM_REQ   = 1'b1;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_DONE   = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BUSY    = 2'd1;
  localparam logic [1:0] STAT_RETIRED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_DISPATCH,
    ST_RESULT
  } sstf_state_t;

  typedef struct packed {
    logic load_in;
    logic apply;
    logic scan_start;
    logic scan;
    logic dispatch;
    logic load_out;
  } sstf_ctrl_t;

  typedef struct packed {
    logic serve_req;
    logic scan_last;
  } sstf_stat_t;

endpackage

// ----- src/sstf_ctrl.sv -----
// ---------------------------------------------------------------------------
// Scheduler controller
// Takes one item through update, decision and, if served, scan and dispatch.
// ---------------------------------------------------------------------------
module sstf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sstf_pkg::sstf_stat_t stat,
  output sstf_pkg::sstf_ctrl_t ctrl
);
  import sstf_pkg::*;

  sstf_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        can_load;

  assign can_load = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_APPLY;
      ST_APPLY:    state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = stat.serve_req ? ST_SCAN : ST_RESULT;
      ST_SCAN:     if (stat.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:    state_nxt = ST_DISPATCH;
      ST_DISPATCH: state_nxt = ST_RESULT;
      ST_RESULT:   if (can_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        ctrl.load_in = in_tvalid;
      end
      ST_APPLY:    ctrl.apply = 1'b1;
      ST_DECIDE:   ctrl.scan_start = stat.serve_req;
      ST_SCAN:     ctrl.scan = 1'b1;
      ST_DRAIN:    ctrl = '0;
      ST_DISPATCH: ctrl.dispatch = 1'b1;
      ST_RESULT:   ctrl.load_out = can_load;
      default:     ctrl = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- src/sstf_dpath.sv -----
// ---------------------------------------------------------------------------
// Scheduler datapath
// Slot state, track memory, nearest-slot scan, head position and result.
// ---------------------------------------------------------------------------
module sstf_dpath #(
  parameter int REQUESTERS = sstf_pkg::DEF_REQUESTERS,
  parameter int TRACK_BITS = sstf_pkg::DEF_TRACK_BITS,
  parameter int IN_W       = 16,
  parameter int OUT_W      = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [IN_W-1:0]              in_tdata,
  input  logic                         in_tuser,
  output logic [OUT_W-1:0]             out_tdata,
  output logic                         out_tuser,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sstf_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [sstf_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [sstf_pkg::DATA_W-1:0]  cfg_prdata,
  input  sstf_pkg::sstf_ctrl_t         ctrl,
  output sstf_pkg::sstf_stat_t         stat
);
  import sstf_pkg::*;

  localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int CNT_W = ($clog2(REQUESTERS + 1) > CFG_W) ? $clog2(REQUESTERS + 1) : CFG_W;

  logic [CFG_W-1:0]      max_queue_r, num_req_r;
  logic                  cmd_r;
  logic [ID_W-1:0]       id_r;
  logic [TRACK_BITS-1:0] track_r;

  logic [REQUESTERS-1:0] slot_valid_r, slot_valid_nxt;
  logic [REQUESTERS-1:0] retired_r, retired_nxt;
  logic [TRACK_BITS-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]      pending_r, pending_nxt;
  logic [CNT_W-1:0]      finished_r, finished_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  served_r, served_nxt;
  logic [IDX_W-1:0]      who_r, who_nxt;

  logic [TRACK_BITS-1:0] track_mem [REQUESTERS];
  logic [TRACK_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]      scan_idx_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  cmp_vld_r;
  logic                  found_r;
  logic [TRACK_BITS-1:0] best_dist_r;
  logic [TRACK_BITS-1:0] best_trk_r;
  logic [IDX_W-1:0]      best_idx_r;

  logic [CNT_W-1:0]      req_cap;
  logic [CNT_W-1:0]      limit;
  logic [CNT_W-1:0]      active;
  logic [CNT_W-1:0]      max_q_ext;
  logic [CNT_W-1:0]      thresh;
  logic [IDX_W-1:0]      idx;
  logic                  in_range;
  logic                  mem_we;
  logic [TRACK_BITS-1:0] span;
  logic [OUT_W-1:0]      pack;

  logic                  cfg_we;

  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_queue_r <= MAX_QUEUE_RST;
      num_req_r   <= NUM_REQ_RST;
    end else if (cfg_we) begin
      if (cfg_paddr[2] == REG_MAX_QUEUE) begin
        max_queue_r <= cfg_pwdata[CFG_W-1:0];
      end else begin
        num_req_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MAX_QUEUE) begin
      cfg_prdata[CFG_W-1:0] = max_queue_r;
    end else begin
      cfg_prdata[CFG_W-1:0] = num_req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r   <= in_tuser;
      id_r    <= in_tdata[ID_W-1:0];
      track_r <= in_tdata[ID_W +: TRACK_BITS];
    end
  end

  assign req_cap   = CNT_W'(REQUESTERS);
  assign limit     = (CNT_W'(num_req_r) > req_cap) ? req_cap : CNT_W'(num_req_r);
  assign active    = (finished_r >= limit) ? '0 : limit - finished_r;
  assign max_q_ext = CNT_W'(max_queue_r);
  assign thresh    = (max_q_ext < active) ? max_q_ext : active;

  assign stat.serve_req = (pending_r != '0) && (pending_r >= thresh);
  assign stat.scan_last = (scan_idx_r == IDX_W'(REQUESTERS - 1));

  assign idx      = IDX_W'(id_r);
  assign in_range = CNT_W'(id_r) < limit;
  assign mem_we   = ctrl.apply && in_range && !retired_r[idx] && !slot_valid_r[idx]
                    && (cmd_r == CMD_SUBMIT);

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    retired_nxt    = retired_r;
    head_nxt       = head_r;
    pending_nxt    = pending_r;
    finished_nxt   = finished_r;
    status_nxt     = status_r;
    served_nxt     = served_r;
    who_nxt        = who_r;
    if (ctrl.apply) begin
      served_nxt = 1'b0;
      who_nxt    = '0;
      priority if (!in_range || retired_r[idx]) begin
        status_nxt = STAT_RETIRED;
      end else if (slot_valid_r[idx]) begin
        status_nxt = STAT_BUSY;
      end else if (cmd_r == CMD_SUBMIT) begin
        slot_valid_nxt[idx] = 1'b1;
        pending_nxt         = pending_r + 1'b1;
        status_nxt          = STAT_OK;
      end else begin
        retired_nxt[idx] = 1'b1;
        finished_nxt     = finished_r + 1'b1;
        status_nxt       = STAT_OK;
      end
    end
    if (ctrl.dispatch && found_r) begin
      slot_valid_nxt[best_idx_r] = 1'b0;
      pending_nxt                = pending_r - 1'b1;
      head_nxt                   = best_trk_r;
      served_nxt                 = 1'b1;
      who_nxt                    = best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      retired_r    <= '0;
      head_r       <= '0;
      pending_r    <= '0;
      finished_r   <= '0;
      status_r     <= STAT_OK;
      served_r     <= 1'b0;
      who_r        <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      retired_r    <= retired_nxt;
      head_r       <= head_nxt;
      pending_r    <= pending_nxt;
      finished_r   <= finished_nxt;
      status_r     <= status_nxt;
      served_r     <= served_nxt;
      who_r        <= who_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      track_mem[idx] <= track_r;
    end
    rd_data_r <= track_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      cmp_vld_r <= ctrl.scan;
      if (ctrl.scan_start) begin
        scan_idx_r <= '0;
      end else if (ctrl.scan) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
  end

  assign span = (rd_data_r >= head_r) ? rd_data_r - head_r : head_r - rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.scan_start) begin
      found_r <= 1'b0;
    end else if (cmp_vld_r && slot_valid_r[cmp_idx_r] && (!found_r || span < best_dist_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r && slot_valid_r[cmp_idx_r] && (!found_r || span < best_dist_r)) begin
      best_dist_r <= span;
      best_trk_r  <= rd_data_r;
      best_idx_r  <= cmp_idx_r;
    end
  end

  always_comb begin
    pack                          = '0;
    pack[1:0]                     = status_r;
    pack[2 +: ID_W]               = ID_W'(who_r);
    pack[2 + ID_W +: TRACK_BITS]  = head_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_tdata <= pack;
      out_tuser <= served_r;
    end
  end

endmodule

// ----- src/sstf_disk_request_scheduler_core.sv -----
// ---------------------------------------------------------------------------
// Shortest-seek-first disk request scheduler
// Per-requester request slots served nearest-track-first from the head.
// ---------------------------------------------------------------------------
// Every accepted item gives exactly one result. An item that leads to no
// dispatch goes from the decision straight to the result stage; one that
// dispatches first scans every slot, since the nearest request is found by
// reading the track memory one slot per cycle through its single read port.
// The result waits in an output register, so a new item is taken while it
// is still held. No clearing pass is needed after reset.
module sstf_disk_request_scheduler_core #(
  parameter int REQUESTERS = sstf_pkg::DEF_REQUESTERS,
  parameter int TRACK_BITS = sstf_pkg::DEF_TRACK_BITS,
  parameter int IN_W       = ((sstf_pkg::ID_W + TRACK_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((2 + sstf_pkg::ID_W + TRACK_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // requester_id, track
  input  logic [IN_W-1:0]             in_tdata,
  // cmd
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status, served_requester, served_track
  output logic [OUT_W-1:0]            out_tdata,
  // served
  output logic                        out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sstf_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [sstf_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [sstf_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import sstf_pkg::*;

  sstf_ctrl_t ctrl;
  sstf_stat_t stat;

  assign cfg_pready = 1'b1;

  sstf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  sstf_dpath #(
    .REQUESTERS (REQUESTERS),
    .TRACK_BITS (TRACK_BITS),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .ctrl        (ctrl),
    .stat        (stat)
  );

endmodule

// ----- src/sstf_chk.sv -----
// ---------------------------------------------------------------------------
// Scheduler port checker
// Watches the scheduler ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "sstf_disk_request_scheduler_core_defines.svh"

module sstf_chk #(
  parameter int OUT_W = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);
  import sstf_pkg::*;

  `SSTF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result item changed while stalled")
  `SSTF_ASSERT_SAME(a_status_code, out_tvalid, out_tdata[1:0] != 2'd3, "undefined status code")
  `SSTF_ASSERT_SAME(a_idle_who, out_tvalid && !out_tuser, out_tdata[2 +: ID_W] == '0, "requester shown without a dispatch")
  `SSTF_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "item taken while another is in work")

endmodule

bind sstf_disk_request_scheduler_core sstf_chk #(
  .OUT_W (OUT_W)
) u_sstf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- bench/sstf_disk_request_scheduler_core_checker.sv -----
// ---------------------------------------------------------------------------
// Scheduler result checker
// Watches the request, result and register ports of the shortest-seek-first
// scheduler, keeps its own copy of the slots, head and register values, works
// out the result of every accepted request and compares each result field by
// field with the oldest one outstanding.
// ---------------------------------------------------------------------------
module sstf_disk_request_scheduler_core_checker
  import sstf_pkg::*;
#(
  parameter int IN_W  = 16,
  parameter int OUT_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  // requester_id, track
  input  logic [IN_W-1:0]   in_tdata,
  // cmd
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  // status, served_requester, served_track
  input  logic [OUT_W-1:0]  out_tdata,
  // served
  input  logic              out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  input  logic              run_done,
  output int                fail_count
);

  localparam int SLOTS = DEF_REQUESTERS;
  localparam int TRK_W = DEF_TRACK_BITS;

  typedef struct packed {
    logic [1:0]       status;
    logic             served;
    logic [ID_W-1:0]  who;
    logic [TRK_W-1:0] head;
  } outcome_t;

  outcome_t         awaited_outcomes[$];
  logic             slot_busy    [SLOTS];
  logic [TRK_W-1:0] slot_trk     [SLOTS];
  logic             retired      [SLOTS];
  logic [TRK_W-1:0] head_track;
  int unsigned      pending_reqs;
  int unsigned      finished_reqs;
  logic [CFG_W-1:0] max_queue;
  logic [CFG_W-1:0] num_requesters;
  logic             leftovers_reported;

  initial fail_count = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_schedule();
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_trk[i]  = '0;
      retired[i]   = 1'b0;
    end
    head_track         = '0;
    pending_reqs       = 0;
    finished_reqs      = 0;
    max_queue          = MAX_QUEUE_RST;
    num_requesters     = NUM_REQ_RST;
    leftovers_reported = 1'b0;
    awaited_outcomes.delete();
  endtask

  task automatic predict_service(input logic cmd, input logic [ID_W-1:0] id,
                                 input logic [TRK_W-1:0] trk);
    int unsigned limit;
    int unsigned active;
    int unsigned thresh;
    int unsigned span;
    int unsigned best;
    logic        found;
    outcome_t    res;
    limit = (num_requesters > SLOTS) ? SLOTS : num_requesters;
    if (id >= limit || retired[id]) begin
      res.status = STAT_RETIRED;
    end else if (slot_busy[id]) begin
      res.status = STAT_BUSY;
    end else if (cmd == CMD_SUBMIT) begin
      slot_busy[id] = 1'b1;
      slot_trk[id]  = trk;
      pending_reqs++;
      res.status = STAT_OK;
    end else begin
      retired[id] = 1'b1;
      finished_reqs++;
      res.status = STAT_OK;
    end
    active = (finished_reqs >= limit) ? 0 : limit - finished_reqs;
    thresh = (max_queue < active) ? max_queue : active;
    res.served = 1'b0;
    res.who    = '0;
    if (pending_reqs > 0 && pending_reqs >= thresh) begin
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i]) begin
          span = (slot_trk[i] >= head_track) ? slot_trk[i] - head_track
                                             : head_track - slot_trk[i];
          if (!found || span < best) begin
            found   = 1'b1;
            best    = span;
            res.who = ID_W'(i);
          end
        end
      end
      if (found) begin
        head_track          = slot_trk[res.who];
        slot_busy[res.who]  = 1'b0;
        pending_reqs--;
        res.served = 1'b1;
      end
    end
    res.head = head_track;
    awaited_outcomes.push_back(res);
  endtask

  task automatic check_outcome();
    outcome_t want;
    if (awaited_outcomes.size() == 0) begin
      report("result arrived with no request outstanding");
    end else begin
      want = awaited_outcomes.pop_front();
      if (out_tdata[1:0] != want.status)
        report($sformatf("status %0d, expected %0d", out_tdata[1:0], want.status));
      if (out_tuser != want.served)
        report($sformatf("served %0d, expected %0d", out_tuser, want.served));
      if (out_tdata[2 +: ID_W] != want.who)
        report($sformatf("served requester %0d, expected %0d",
                         out_tdata[2 +: ID_W], want.who));
      if (out_tdata[2 + ID_W +: TRK_W] != want.head)
        report($sformatf("served track %0d, expected %0d",
                         out_tdata[2 + ID_W +: TRK_W], want.head));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_schedule();
    end else begin
      if (out_tvalid && out_tready)
        check_outcome();
      if (in_tvalid && in_tready)
        predict_service(in_tuser, in_tdata[ID_W-1:0], in_tdata[ID_W +: TRK_W]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == {REG_MAX_QUEUE, 2'b00})
          max_queue = cfg_pwdata[CFG_W-1:0];
        else if (cfg_paddr == {REG_NUM_REQ, 2'b00})
          num_requesters = cfg_pwdata[CFG_W-1:0];
      end
      if (run_done && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        if (awaited_outcomes.size() != 0)
          report($sformatf("%0d results never arrived", awaited_outcomes.size()));
      end
    end
  end

endmodule

// ----- bench/sstf_disk_request_scheduler_core_test.sv -----
// ---------------------------------------------------------------------------
// Scheduler testbench
// Drives track requests and done items into the shortest-seek-first scheduler
// under several register settings and handshake pacings, starting with a
// directed sequence and retiring every requester near the end; the checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module sstf_disk_request_scheduler_core_test;
  import sstf_pkg::*;

  localparam int TRK_W       = DEF_TRACK_BITS;
  localparam int IN_W        = ((ID_W + TRK_W + 7) / 8) * 8;
  localparam int OUT_W       = ((2 + ID_W + TRK_W + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 4000;

  typedef enum int {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              run_done;
  int                fail_count;
  int                sent_items;
  int                taken_results;
  int                quiet_cycles;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       id_limit;
  logic [TRK_W-1:0]  hot_spot;

  sstf_disk_request_scheduler_core DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  sstf_disk_request_scheduler_core_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .run_done, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready)
      taken_results <= taken_results + 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("sstf_disk_request_scheduler_core verification failed");
      $finish;
    end
  end

  task automatic issue_request(input logic cmd, input logic [ID_W-1:0] id,
                               input logic [TRK_W-1:0] trk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({trk, id});
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (taken_results != sent_items) @(posedge clk);
  endtask

  task automatic write_register(input logic index, input logic [CFG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] mq, input logic [CFG_W-1:0] nr,
                           input pace_t pace);
    wait_drained();
    write_register(REG_MAX_QUEUE, mq);
    write_register(REG_NUM_REQ, nr);
    id_limit = (nr > DEF_REQUESTERS) ? DEF_REQUESTERS : nr;
    case (pace)
      PACE_FULL: begin
        idle_pct = 0;  stall_pct = 0;
      end
      PACE_SENDER: begin
        idle_pct = 51; stall_pct = 0;
      end
      PACE_RECEIVER: begin
        idle_pct = 0;  stall_pct = 51;
      end
      default: begin
        idle_pct = 6;  stall_pct = 6;
      end
    endcase
  endtask

  function automatic logic [TRK_W-1:0] pick_track();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    else if (r < 16)
      return '1;
    else if (r < 50)
      return TRK_W'(hot_spot + $urandom_range(6));
    else
      return TRK_W'($urandom);
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] mq, input logic [CFG_W-1:0] nr,
                           input pace_t pace, input int items, input int retire_pct);
    logic [ID_W-1:0] id;
    logic            cmd;
    configure(mq, nr, pace);
    hot_spot = TRK_W'($urandom);
    repeat (items) begin
      id = ID_W'($urandom_range(DEF_REQUESTERS - 1));
      if (retire_pct > 0)
        cmd = ($urandom_range(99) < retire_pct) ? CMD_DONE : CMD_SUBMIT;
      else
        cmd = (id >= id_limit && $urandom_range(1)) ? CMD_DONE : CMD_SUBMIT;
      issue_request(cmd, id, pick_track());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = CMD_SUBMIT;
    out_tready    = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    run_done      = 1'b0;
    sent_items    = 0;
    taken_results = 0;
    quiet_cycles  = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    id_limit      = DEF_REQUESTERS;
    hot_spot      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(4'd3, 4'd8, PACE_FULL);
    issue_request(CMD_SUBMIT, 3'd0, 10'd1023);
    issue_request(CMD_SUBMIT, 3'd0, 10'd5);
    issue_request(CMD_DONE,   3'd0, 10'd0);
    issue_request(CMD_SUBMIT, 3'd7, 10'd0);
    issue_request(CMD_SUBMIT, 3'd3, 10'd10);
    issue_request(CMD_SUBMIT, 3'd5, 10'd20);
    issue_request(CMD_SUBMIT, 3'd1, 10'd30);
    issue_request(CMD_SUBMIT, 3'd2, 10'd10);
    configure(4'd0, 4'd8, PACE_FULL);
    issue_request(CMD_SUBMIT, 3'd4, 10'd512);
    configure(4'd0, 4'd4, PACE_FULL);
    issue_request(CMD_SUBMIT, 3'd6, 10'd100);
    issue_request(CMD_DONE,   3'd5, 10'd1023);
    issue_request(CMD_SUBMIT, 3'd1, 10'd700);
    configure(4'd15, 4'd15, PACE_FULL);
    issue_request(CMD_SUBMIT, 3'd6, 10'd3);
    issue_request(CMD_SUBMIT, 3'd2, 10'd1023);
    issue_request(CMD_SUBMIT, 3'd7, 10'd1);
    issue_request(CMD_SUBMIT, 3'd5, 10'd1022);

    run_phase(4'd8,  4'd8,  PACE_FULL,      60, 0);
    run_phase(4'd2,  4'd3,  PACE_SENDER,   100, 0);
    run_phase(4'd15, 4'd15, PACE_RECEIVER, 100, 0);
    run_phase(4'd1,  4'd8,  PACE_BOTH,      80, 0);
    run_phase(4'd0,  4'd6,  PACE_FULL,      80, 0);
    run_phase(4'd5,  4'd7,  PACE_SENDER,    60, 0);
    run_phase(4'd1,  4'd8,  PACE_RECEIVER,  90, 25);
    for (int i = 0; i < DEF_REQUESTERS; i++)
      issue_request(CMD_DONE, ID_W'(i), pick_track());
    issue_request(CMD_SUBMIT, 3'd0, pick_track());
    configure(4'd1, 4'd0, PACE_BOTH);
    repeat (6)
      issue_request(1'($urandom_range(1)), ID_W'($urandom_range(7)), pick_track());

    wait_drained();
    repeat (20) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("sstf_disk_request_scheduler_core verification clean");
    else
      $display("sstf_disk_request_scheduler_core verification failed");
    $finish;
  end

endmodule
